// File: hw/rtl/clb_pkg.sv
// shared types, codes and constants of the circular line buffer
package clb_pkg;

    localparam int CLB_BUFFER_BYTES = 64;
    localparam logic [7:0] CLB_DELIM_RESET = 8'd10;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_GET   = 2'd1,
        OP_PURGE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_LINE_BYTE = 3'd2,
        ST_NO_LINE   = 3'd3,
        ST_PURGED    = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_PURGE,
        S_MISS
    } t_state;

    typedef struct packed {
        logic    write;
        logic    scan_init;
        logic    scan_rd;
        logic    scan_step;
        logic    found;
        logic    emit_rd;
        logic    emit_step;
        logic    purge_commit;
        logic    clear;
        logic    load_out;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic full;
        logic scan_end;
        logic match;
        logic emit_last;
    } t_sts;

endpackage

// File: hw/rtl/clb_in_if.sv
// input channel: operation and data byte with valid/ready
interface clb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// File: hw/rtl/clb_out_if.sv
// result channel: status, line byte, last flag and free count with valid/ready
interface clb_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] line_byte;
    logic       last;
    logic [6:0] free_count;

    modport source (output valid, output status, output line_byte, output last,
                    output free_count, input ready);
    modport sink   (input valid, input status, input line_byte, input last,
                    input free_count, output ready);
endinterface

// File: hw/rtl/clb_ctrl.sv
// controller state machine: sequences write, line scan, line emit, purge and clear
module clb_ctrl
    import clb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_operation,
    output logic       o_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_is_get, n_is_get;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_is_get <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_is_get <= n_is_get;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_is_get = r_is_get;
        o_ready  = 1'b0;
        o_cmd    = '0;
        o_cmd.status = ST_ACCEPTED;
        unique case (r_state)
            S_IDLE: begin
                o_ready = i_sts.out_free;
                if (i_valid && i_sts.out_free) begin
                    unique case (i_operation)
                        OP_WRITE: begin
                            o_cmd.load_out = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.status = ST_DROPPED;
                            end else begin
                                o_cmd.write  = 1'b1;
                                o_cmd.status = ST_ACCEPTED;
                            end
                        end
                        OP_GET, OP_PURGE: begin
                            o_cmd.scan_init = 1'b1;
                            n_is_get        = (i_operation == OP_GET);
                            n_state         = S_SCAN_RD;
                        end
                        // unused operation code: transaction taken, no result
                        default: ;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_sts.match) begin
                    o_cmd.found = 1'b1;
                    n_state     = r_is_get ? S_EMIT_RD : S_PURGE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_step = 1'b1;
                    o_cmd.load_out  = 1'b1;
                    o_cmd.status    = ST_LINE_BYTE;
                    n_state         = i_sts.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_PURGE: begin
                if (i_sts.out_free) begin
                    o_cmd.purge_commit = 1'b1;
                    o_cmd.load_out     = 1'b1;
                    o_cmd.status       = ST_PURGED;
                    n_state            = S_IDLE;
                end
            end
            S_MISS: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (r_is_get) begin
                        o_cmd.status = ST_NO_LINE;
                    end else begin
                        o_cmd.clear  = 1'b1;
                        o_cmd.status = ST_CLEARED;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/clb_datapath.sv
// datapath: byte ring memory, positions, fill count, scan logic and result register
module clb_datapath
    import clb_pkg::*;
#(
    parameter int BUFFER_BYTES = CLB_BUFFER_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [7:0] i_data_byte,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    clb_out_if.source  o_result
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_BYTES - 1);
    localparam logic [CW-1:0] DEPTH     = CW'(BUFFER_BYTES);

    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_rd_data;
    logic [7:0]    r_delim;
    logic [AW-1:0] r_rd_pos, n_rd_pos;
    logic [AW-1:0] r_wr_pos;
    logic [AW-1:0] r_scan_pos;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_scan_cnt;
    logic [CW-1:0] r_len;
    logic [AW-1:0] rd_addr;

    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic [6:0]    r_out_free;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    // memory: one write port, one registered read port
    assign rd_addr = i_cmd.emit_rd ? r_rd_pos : r_scan_pos;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[r_wr_pos] <= i_data_byte;
        end
        if (i_cmd.scan_rd || i_cmd.emit_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_used   = r_used;
        n_rd_pos = r_rd_pos;
        if (i_cmd.write) begin
            n_used = r_used + CW'(1);
        end else if (i_cmd.emit_step) begin
            n_used   = r_used - CW'(1);
            n_rd_pos = ring_next(r_rd_pos);
        end else if (i_cmd.purge_commit) begin
            // scan position still sits on the delimiter
            n_used   = r_used - r_len;
            n_rd_pos = ring_next(r_scan_pos);
        end else if (i_cmd.clear) begin
            n_used   = '0;
            n_rd_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos <= '0;
            r_wr_pos <= '0;
            r_used   <= '0;
            r_delim  <= CLB_DELIM_RESET;
        end else begin
            r_rd_pos <= n_rd_pos;
            r_used   <= n_used;
            if (i_cmd.write) begin
                r_wr_pos <= ring_next(r_wr_pos);
            end else if (i_cmd.clear) begin
                r_wr_pos <= '0;
            end
            if (i_cfg_wr_en) begin
                r_delim <= i_cfg_wr_data;
            end
        end
    end

    // scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan_pos <= r_rd_pos;
            r_scan_cnt <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_pos <= ring_next(r_scan_pos);
            r_scan_cnt <= r_scan_cnt + CW'(1);
        end
        if (i_cmd.found) begin
            r_len <= r_scan_cnt + CW'(1);
        end else if (i_cmd.emit_step) begin
            r_len <= r_len - CW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.status;
            r_out_byte   <= (i_cmd.status == ST_LINE_BYTE) ? r_rd_data : 8'd0;
            r_out_last   <= (i_cmd.status != ST_LINE_BYTE) || (r_len == CW'(1));
            r_out_free   <= 7'(DEPTH - n_used);
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_out_status;
    assign o_result.line_byte  = r_out_byte;
    assign o_result.last       = r_out_last;
    assign o_result.free_count = r_out_free;

    assign o_sts.out_free  = !r_out_valid || o_result.ready;
    assign o_sts.full      = (r_used == DEPTH);
    assign o_sts.scan_end  = (r_scan_cnt == r_used);
    assign o_sts.match     = (r_rd_data == r_delim);
    assign o_sts.emit_last = (r_len == CW'(1));

endmodule

// File: hw/rtl/circular_line_buffer.sv
// top level of the circular line buffer: controller plus datapath
// write: result on the cycle after the transaction, one write per cycle while results are taken
// get line: each stored byte is scanned in a read state and a check state, then each line byte is emitted
//   in a read state and an output state; no line found and purge each end the scan in a result state
// one operation in flight at a time; a stalled result holds the controller
// reset: read and write positions, fill count and result valid cleared, delimiter newline, ring kept
module circular_line_buffer
    import clb_pkg::*;
#(
    parameter int BUFFER_BYTES = CLB_BUFFER_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    clb_in_if.sink     i_item,
    clb_out_if.source  o_result
);

    t_cmd cmd;
    t_sts sts;
    logic ready;

    clb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_item.valid),
        .i_operation (i_item.operation),
        .o_ready     (ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    assign i_item.ready = ready;

    clb_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_data_byte   (i_item.data_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (o_result)
    );

endmodule
